// ===== src/swmm_pkg.sv =====
// Shared constants and controller/datapath interface types for the sliding window min/max block.
package swmm_pkg;

    // Widths of the stream and of the window register, the reset window length and the default queue depth.
    localparam int VAL_W          = 32;
    localparam int CFG_W          = 11;
    localparam int WIN_RESET      = 3;
    localparam int WINDOW_MAX_DEF = 1024;

    // Queue indexes: one monotonic queue for the minimum, one for the maximum.
    localparam int Q_MIN = 0;
    localparam int Q_MAX = 1;
    localparam int NUM_Q = 2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the accepted request
        logic rd_head;   // read the head entry of both queues
        logic exp_chk;   // expire a head that has left the window
        logic rd_tail;   // read the tail entry of both queues
        logic tail_chk;  // drop a dominated tail entry
        logic push;      // append the new sample to both queues
        logic emit;      // load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic all_done;  // no queue has tail entries left to test
        logic out_busy;  // result register full and stalled
    } t_sts;

endpackage

// ===== src/swmm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module swmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/swmm_ctrl.sv =====
// Sequencer that steps one request through expiry, tail pruning, push and result.
module swmm_ctrl
    import swmm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_EXP_RD   = 8'b0000_0010,
        S_EXP_CHK  = 8'b0000_0100,
        S_TAIL_RD  = 8'b0000_1000,
        S_TAIL_CHK = 8'b0001_0000,
        S_PUSH     = 8'b0010_0000,
        S_HEAD_RD  = 8'b0100_0000,
        S_EMIT     = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXP_RD;
                end
            end
            S_EXP_RD: begin
                o_cmd.rd_head = 1'b1;
                n_state       = S_EXP_CHK;
            end
            S_EXP_CHK: begin
                o_cmd.exp_chk = 1'b1;
                n_state       = S_TAIL_RD;
            end
            S_TAIL_RD: begin
                if (i_sts.all_done) begin
                    n_state = S_PUSH;
                end else begin
                    o_cmd.rd_tail = 1'b1;
                    n_state       = S_TAIL_CHK;
                end
            end
            S_TAIL_CHK: begin
                o_cmd.tail_chk = 1'b1;
                n_state        = S_TAIL_RD;
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = S_HEAD_RD;
            end
            S_HEAD_RD: begin
                o_cmd.rd_head = 1'b1;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Requests are taken only between items.
    assign o_stall = (r_state != S_IDLE);

    // Tail reads happen only while some queue still has entries to test.
    a_tail_rd_needed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_tail |-> !i_sts.all_done)
        else $error("tail read issued with all queues done");

    // An accepted request goes through the head read and the expiry check before the push step.
    a_load_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> ##1 !o_cmd.push)
        else $error("push too soon after load");

    // A result is never loaded while the previous one is stalled.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !i_sts.out_busy)
        else $error("result loaded over a stalled result");

endmodule

// ===== src/swmm_dp.sv =====
// Datapath: two monotonic queues in RAM, their bounds, the stream position and the result register.
module swmm_dp
    import swmm_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_W-1:0]        i_cfg_wdata,
    input  logic signed [VAL_W-1:0] i_sample,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic                    i_stall,
    output logic                    o_valid,
    output logic signed [VAL_W-1:0] o_window_min,
    output logic signed [VAL_W-1:0] o_window_max
);

    localparam int IDX_W   = $clog2(WINDOW_MAX);
    localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int POS_MOD = 2 * WINDOW_MAX;
    localparam int POS_W   = $clog2(POS_MOD);
    localparam int AGE_W   = POS_W + 1;
    localparam int ENT_W   = VAL_W + POS_W;
    localparam int WIN_RST = (WIN_RESET > WINDOW_MAX) ? WINDOW_MAX : WIN_RESET;

    // Ring index of head plus offset, wrapped once at the queue depth.
    function automatic logic [IDX_W-1:0] f_slot(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(off);
        if (sum >= SUM_W'(WINDOW_MAX)) begin
            sum = sum - SUM_W'(WINDOW_MAX);
        end
        return sum[IDX_W-1:0];
    endfunction

    logic signed [VAL_W-1:0] r_sample;
    logic [CNT_W-1:0]        r_win;
    logic [POS_W-1:0]        r_pos;
    logic                    r_filled;
    logic [IDX_W-1:0]        r_head [NUM_Q];
    logic [IDX_W-1:0]        n_head [NUM_Q];
    logic [CNT_W-1:0]        r_cnt  [NUM_Q];
    logic [CNT_W-1:0]        n_cnt  [NUM_Q];
    logic [NUM_Q-1:0]        r_done;
    logic [NUM_Q-1:0]        n_done;
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_min;
    logic signed [VAL_W-1:0] r_out_max;

    logic [CNT_W-1:0]        cfg_win;
    logic [ENT_W-1:0]        rd_data [NUM_Q];
    logic signed [VAL_W-1:0] rd_val  [NUM_Q];
    logic [POS_W-1:0]        rd_pos  [NUM_Q];
    logic [AGE_W-1:0]        age     [NUM_Q];
    logic [NUM_Q-1:0]        expire;
    logic [NUM_Q-1:0]        drop;
    logic [IDX_W-1:0]        raddr   [NUM_Q];
    logic [IDX_W-1:0]        waddr   [NUM_Q];
    logic [NUM_Q-1:0]        wen;
    logic [POS_W-1:0]        pos_inc;

    // Window register value: zero means one, large values saturate at the depth.
    assign cfg_win = (i_cfg_wdata == '0) ? CNT_W'(1) :
                     (32'(i_cfg_wdata) > 32'(WINDOW_MAX)) ? CNT_W'(WINDOW_MAX) :
                     CNT_W'(i_cfg_wdata);

    // Per-queue storage, compare and addressing.
    for (genvar q = 0; q < NUM_Q; q++) begin : g_q
        swmm_ram #(
            .WIDTH (ENT_W),
            .DEPTH (WINDOW_MAX)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (wen[q]),
            .i_waddr (waddr[q]),
            .i_wdata ({r_sample, r_pos}),
            .i_re    (i_cmd.rd_head | i_cmd.rd_tail),
            .i_raddr (raddr[q]),
            .o_rdata (rd_data[q])
        );

        assign rd_val[q] = rd_data[q][ENT_W-1:POS_W];
        assign rd_pos[q] = rd_data[q][POS_W-1:0];

        // Age of the head entry, modulo the position range.
        assign age[q] = AGE_W'(r_pos)
                      + ((r_pos >= rd_pos[q]) ? AGE_W'(0) : AGE_W'(POS_MOD))
                      - AGE_W'(rd_pos[q]);
        assign expire[q] = (r_cnt[q] != '0) && (age[q] >= AGE_W'(r_win));

        // Newer equal samples replace older ones in both queues.
        if (q == Q_MIN) begin : g_min
            assign drop[q] = (rd_val[q] >= r_sample);
        end else begin : g_max
            assign drop[q] = (rd_val[q] <= r_sample);
        end

        assign raddr[q] = i_cmd.rd_tail
                        ? f_slot(r_head[q], (r_cnt[q] == '0) ? '0 : r_cnt[q] - 1'b1)
                        : r_head[q];
        assign waddr[q] = f_slot(r_head[q], r_cnt[q]);
        assign wen[q]   = i_cmd.push && (r_cnt[q] < CNT_W'(WINDOW_MAX));
    end

    // Queue bounds update.
    always_comb begin
        for (int q = 0; q < NUM_Q; q++) begin
            n_head[q] = r_head[q];
            n_cnt[q]  = r_cnt[q];
            n_done[q] = r_done[q];
            if (i_cfg_we) begin
                n_head[q] = '0;
                n_cnt[q]  = '0;
            end else if (i_cmd.exp_chk) begin
                if (expire[q]) begin
                    n_head[q] = f_slot(r_head[q], CNT_W'(1));
                    n_cnt[q]  = r_cnt[q] - 1'b1;
                    n_done[q] = (r_cnt[q] == CNT_W'(1));
                end else begin
                    n_done[q] = (r_cnt[q] == '0);
                end
            end else if (i_cmd.tail_chk && !r_done[q]) begin
                if (drop[q]) begin
                    n_cnt[q]  = r_cnt[q] - 1'b1;
                    n_done[q] = (r_cnt[q] == CNT_W'(1));
                end else begin
                    n_done[q] = 1'b1;
                end
            end else if (wen[q]) begin
                n_cnt[q] = r_cnt[q] + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < NUM_Q; q++) begin
                r_head[q] <= '0;
                r_cnt[q]  <= '0;
            end
            r_done <= '0;
        end else begin
            for (int q = 0; q < NUM_Q; q++) begin
                r_head[q] <= n_head[q];
                r_cnt[q]  <= n_cnt[q];
            end
            r_done <= n_done;
        end
    end

    // Sample capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
        end
    end

    // Window register, stream position and fill flag.
    assign pos_inc = (r_pos == POS_W'(POS_MOD - 1)) ? '0 : r_pos + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= CNT_W'(WIN_RST);
            r_pos    <= '0;
            r_filled <= 1'b0;
        end else if (i_cfg_we) begin
            r_win    <= cfg_win;
            r_pos    <= '0;
            r_filled <= 1'b0;
        end else if (i_cmd.push) begin
            r_pos <= pos_inc;
            if ((AGE_W'(r_pos) + 1'b1) >= AGE_W'(r_win)) begin
                r_filled <= 1'b1;
            end
        end
    end

    // Result register: the head of each queue once the window has filled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit && r_filled) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit && r_filled) begin
            r_out_min <= rd_val[Q_MIN];
            r_out_max <= rd_val[Q_MAX];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_window_min = r_out_min;
    assign o_window_max = r_out_max;
    assign o_sts.all_done = &r_done;
    assign o_sts.out_busy = r_out_valid && i_stall;

    // A queue never holds more entries than its depth.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[Q_MIN] <= CNT_W'(WINDOW_MAX)) && (r_cnt[Q_MAX] <= CNT_W'(WINDOW_MAX)))
        else $error("queue count beyond depth");

    // After a push both queues hold at least the new sample.
    a_push_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |=> (r_cnt[Q_MIN] != '0) && (r_cnt[Q_MAX] != '0))
        else $error("queue empty after push");

    // The window minimum never exceeds the window maximum.
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_filled) |-> (rd_val[Q_MIN] <= rd_val[Q_MAX]))
        else $error("window minimum above maximum");

    // A result loaded once the window is full is presented next cycle.
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_filled) |=> r_out_valid)
        else $error("result lost after load");

endmodule

// ===== src/sliding_window_min_max.sv =====
// Top level of the sliding window minimum and maximum filter.
//
// Input channel: i_valid / o_stall with payload i_sample (signed 32 bits). A request is
// taken at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_window_min and o_window_max, the smallest and
// largest of the last window samples. Before the window has filled, a request yields
// no result.
// Configuration: i_cfg_we writes i_cfg_wdata as the window length (zero acts as one,
// values above WINDOW_MAX act as WINDOW_MAX) and restarts the stream with empty queues.
// Write it only while no request is in flight.
// Sequence: requests are taken one at a time; each passes a head read, the expiry check,
// the tail tests, the push, a second head read and the result load. The tail tests go on
// until every queue is done: one per entry dropped, plus one for the entry that stops the
// pruning when the queue does not run empty; each tail test is a RAM read and a compare.
// Reset (i_rst_n low at a clock edge) sets the window to 3, empties both queues and
// drops any pending result. The queue RAMs need no clearing pass.
// A stalled result holds in the output register; the next request is still taken and
// worked on, and waits in its last step until the output register is free.
module sliding_window_min_max
    import swmm_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_W-1:0]        i_cfg_wdata,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [VAL_W-1:0] i_sample,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [VAL_W-1:0] o_window_min,
    output logic signed [VAL_W-1:0] o_window_max
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer.
    swmm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Queues, bounds and result register.
    swmm_dp #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_sample     (i_sample),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_window_min (o_window_min),
        .o_window_max (o_window_max)
    );

endmodule

// ===== test/sliding_window_min_max_tb.sv =====
// Self-checking testbench for the sliding window minimum and maximum filter.
module sliding_window_min_max_tb
    import swmm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_W         = $clog2(2 * WINDOW_MAX_DEF);
    localparam int SETTLE_CYCLES = 8 + 2 * WINDOW_MAX_DEF + 16;
    localparam int DRAIN_LIMIT   = 40000;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_PCT      = 29;

    // Running window extremes predicted from accepted requests, and the results still owed.
    class minmax_scoreboard;
        typedef struct {
            logic signed [VAL_W-1:0] value;
            logic [POS_W-1:0]        tag;
        } t_entry;

        typedef struct {
            logic signed [VAL_W-1:0] lo;
            logic signed [VAL_W-1:0] hi;
        } t_extrema;

        int unsigned      win;
        int unsigned      taken;
        logic [POS_W-1:0] position;
        t_entry           lo_deque[$];
        t_entry           hi_deque[$];
        t_extrema         owed_extrema[$];
        int               mismatches;

        function new();
            mismatches = 0;
            restart(WIN_RESET);
        endfunction

        // A register write saturates the length and starts a fresh stream.
        function void restart(int unsigned length);
            if (length == 0) begin
                win = 1;
            end else if (length > WINDOW_MAX_DEF) begin
                win = WINDOW_MAX_DEF;
            end else begin
                win = length;
            end
            taken    = 0;
            position = '0;
            lo_deque.delete();
            hi_deque.delete();
        endfunction

        function int pending();
            return owed_extrema.size();
        endfunction

        // Update both monotonic deques with one accepted request.
        function void take_sample(logic signed [VAL_W-1:0] s);
            t_entry           e;
            t_extrema         x;
            logic [POS_W-1:0] age;
            e.value = s;
            e.tag   = position;
            // Heads that have left the window go first.
            while (lo_deque.size() != 0) begin
                age = position - lo_deque[0].tag;
                if (age < win) break;
                void'(lo_deque.pop_front());
            end
            while (hi_deque.size() != 0) begin
                age = position - hi_deque[0].tag;
                if (age < win) break;
                void'(hi_deque.pop_front());
            end
            // Tail entries the new sample dominates are dropped; equal ones too.
            while (lo_deque.size() != 0 && lo_deque[$].value >= s) void'(lo_deque.pop_back());
            while (hi_deque.size() != 0 && hi_deque[$].value <= s) void'(hi_deque.pop_back());
            lo_deque.push_back(e);
            hi_deque.push_back(e);
            position = position + 1'b1;
            if (taken < win) taken++;
            if (taken >= win) begin
                x.lo = lo_deque[0].value;
                x.hi = hi_deque[0].value;
                owed_extrema.push_back(x);
            end
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_extrema(logic signed [VAL_W-1:0] lo, logic signed [VAL_W-1:0] hi);
            t_extrema x;
            if (owed_extrema.size() == 0) begin
                report($sformatf("result min %0d max %0d with nothing owed", lo, hi));
                return;
            end
            x = owed_extrema.pop_front();
            if (lo !== x.lo) report($sformatf("window_min %0d, predicted %0d", lo, x.lo));
            if (hi !== x.hi) report($sformatf("window_max %0d, predicted %0d", hi, x.hi));
        endtask

        task flush_leftovers();
            if (owed_extrema.size() != 0) begin
                report($sformatf("%0d results never arrived", owed_extrema.size()));
                owed_extrema.delete();
            end
        endtask
    endclass

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_cfg_we    = 1'b0;
    logic [CFG_W-1:0]        i_cfg_wdata = '0;
    logic                    i_valid     = 1'b0;
    logic                    o_stall;
    logic signed [VAL_W-1:0] i_sample    = '0;
    logic                    o_valid;
    logic                    i_stall     = 1'b0;
    logic signed [VAL_W-1:0] o_window_min;
    logic signed [VAL_W-1:0] o_window_max;

    minmax_scoreboard sb;
    bit               quiet        = 1'b0;
    bit               hold_request = 1'b0;

    sliding_window_min_max i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_window_min (o_window_min),
        .o_window_max (o_window_max)
    );

    // Clock: 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(100_000_000);
        $display("sliding_window_min_max_tb: done, errors");
        $finish;
    end

    function automatic logic signed [VAL_W-1:0] extreme_value();
        case ($urandom_range(3))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sd0;
            default: return -32'sd1;
        endcase
    endfunction

    // Mix of full-range, clustered (many ties) and extreme samples.
    function automatic logic signed [VAL_W-1:0] rand_value();
        int sel;
        sel = $urandom_range(7);
        if (sel < 4) return $signed($urandom());
        if (sel < 6) return $signed(32'($urandom_range(0, 15))) - 32'sd8;
        return extreme_value();
    endfunction

    // Offer one request, idling at random first, and hold it until it is taken.
    task automatic send_sample(input logic signed [VAL_W-1:0] s);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.take_sample(s);
    endtask

    // Random stream built from bursts: noise, ramps ending in a dip or a jump, tie runs, extremes.
    task automatic run_stream(input int n, input int max_ramp);
        int                      sent;
        int                      kind;
        int                      len;
        int                      k;
        logic signed [VAL_W-1:0] base;
        logic signed [VAL_W-1:0] step;
        logic signed [VAL_W-1:0] v;
        sent = 0;
        while (sent < n) begin
            kind = $urandom_range(9);
            base = $signed(32'($urandom_range(0, 2_000_000))) - 32'sd1_000_000;
            step = $urandom_range(1, 1000);
            case (kind)
                0, 1, 2, 3: len = $urandom_range(1, 20);
                4, 5, 6, 7: len = $urandom_range(2, max_ramp);
                8: begin
                    len  = $urandom_range(2, 10);
                    base = rand_value();
                end
                default: len = $urandom_range(1, 6);
            endcase
            if (len > n - sent) len = n - sent;
            for (k = 0; k < len; k++) begin
                case (kind)
                    0, 1, 2, 3: v = rand_value();
                    // Rising run then a dip clears the min deque's tail.
                    4, 5: v = (k == len - 1) ? base - 32'sd1 : base + k * step;
                    // Falling run then a jump clears the max deque's tail.
                    6, 7: v = (k == len - 1) ? base + 32'sd1 : base - k * step;
                    8: v = base;
                    default: v = extreme_value();
                endcase
                send_sample(v);
            end
            sent += len;
        end
        i_valid <= 1'b0;
    endtask

    // Wait for every owed result, then let a result-less request finish.
    task automatic settle();
        int waited;
        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        sb.flush_leftovers();
    endtask

    // Register write; only called with the block idle.
    task automatic set_window(input logic [CFG_W-1:0] length);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= length;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.restart(length);
        @(posedge i_clk);
    endtask

    // Result side: check each accepted result and stall at random or on request.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) sb.check_extrema(o_window_min, o_window_max);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Request side: directed corners at the reset window, then random phases.
    initial begin : stimulus
        logic signed [VAL_W-1:0] corners [20];
        corners = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd1,
                    32'sd5, 32'sd5, 32'sd5, 32'sd10, 32'sd20, 32'sd30, 32'sd40,
                    32'sd30, 32'sd20, 32'sd10, 32'sh8000_0000, 32'sh8000_0000,
                    32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -32'sd2};
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corners[k]) send_sample(corners[k]);
        i_valid <= 1'b0;
        settle();

        // Zero acts as a window of one; the receiver holds off so the input backs up.
        set_window(11'd0);
        hold_request = 1'b1;
        run_stream(150, 8);
        settle();

        // A stretch with no idling on either side.
        quiet = 1'b1;
        set_window(11'd2);
        run_stream(150, 8);
        settle();
        quiet = 1'b0;

        // Largest exact window, left unfilled, then restarted by the next write.
        set_window(11'd1024);
        run_stream(40, 40);
        settle();

        // All-ones value saturates to the largest window; long ramps stress the tail drops.
        set_window(11'd2047);
        run_stream(1150, 700);
        settle();

        // Back-to-back writes: the last one wins.
        set_window(11'd1025);
        set_window(11'd5);
        run_stream(100, 16);
        settle();

        set_window(CFG_W'($urandom_range(3, 64)));
        run_stream(100, 64);
        settle();

        set_window(11'd1);
        run_stream(60, 8);
        settle();

        if (sb.mismatches == 0) begin
            $display("sliding_window_min_max_tb: done, clean");
        end else begin
            $display("sliding_window_min_max_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/swmm_pkg.sv
src/swmm_ram.sv
src/swmm_ctrl.sv
src/swmm_dp.sv
src/sliding_window_min_max.sv
test/sliding_window_min_max_tb.sv
